/* design/rse_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rse_pkg: shared definitions for the RPN stack evaluator
// Widths, command and status codes, and the controller/datapath bundles.
// ---------------------------------------------------------------------------
package rse_pkg;

    localparam int WORD_W              = 32;
    localparam int CMD_W               = 3;
    localparam int STAT_W              = 2;
    localparam int DEFAULT_STACK_DEPTH = 128;
    localparam int DEFAULT_FRAC_BITS   = 16;

    // Token commands
    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_UNDER = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVER  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DIVZ  = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic              load_in;
        logic              push;
        logic              set_err;
        logic [STAT_W-1:0] err_code;
        logic              rd_en;
        logic              alu_wb;
        logic              mul_start;
        logic              mul_wb;
        logic              div_start;
        logic              div_wb;
        logic              emit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             last;
        logic             err_set;
        logic             sp_lt2;
        logic             sp_full;
        logic             top_zero;
        logic             div_done;
        logic             out_free;
    } ctrl_sts_t;

endpackage

/* design/rse_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rse_if: valid/ready channels of the RPN stack evaluator
// Token channel (command, value, last) and result channel (result, status).
// ---------------------------------------------------------------------------
interface rse_token_if;
    logic                              valid;
    logic                              ready;
    logic [rse_pkg::CMD_W-1:0]         command;
    logic signed [rse_pkg::WORD_W-1:0] value;
    logic                              last;

    modport source (output valid, output command, output value, output last, input ready);
    modport sink   (input valid, input command, input value, input last, output ready);
endinterface

interface rse_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [rse_pkg::WORD_W-1:0] result;
    logic [rse_pkg::STAT_W-1:0]        status;

    modport source (output valid, output result, output status, input ready);
    modport sink   (input valid, input result, input status, output ready);
endinterface

/* design/rse_divider.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rse_divider: restoring unsigned divider, one quotient bit per cycle
// Busy after start until all WORD_W + FRAC_BITS quotient bits are in, then
// pulses done for one cycle with the quotient held.
// ---------------------------------------------------------------------------
module rse_divider #(
    parameter int FRAC_BITS = rse_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic [rse_pkg::WORD_W+FRAC_BITS-1:0]    dividend,
    input  logic [rse_pkg::WORD_W-1:0]              divisor,
    output logic                                    done,
    output logic [rse_pkg::WORD_W+FRAC_BITS-1:0]    quotient
);

    localparam int NW = rse_pkg::WORD_W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]                 num_reg;
    logic [rse_pkg::WORD_W-1:0]    rem_reg;
    logic [rse_pkg::WORD_W-1:0]    den_reg;
    logic [CW-1:0]                 count_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [rse_pkg::WORD_W:0]      trial;
    logic                          ge;
    logic [rse_pkg::WORD_W:0]      diff;

    always_comb
    begin
        trial = {rem_reg, num_reg[NW-1]};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CW'(NW);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CW'(1);
                if (count_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift the dividend out, the quotient bits in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[rse_pkg::WORD_W-1:0] : trial[rse_pkg::WORD_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

/* design/rse_datapath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rse_datapath: operand stack, arithmetic and result register
// Top of stack lives in a register; entries below it live in the memory.
// ---------------------------------------------------------------------------
module rse_datapath #(
    parameter int STACK_DEPTH = rse_pkg::DEFAULT_STACK_DEPTH,
    parameter int FRAC_BITS   = rse_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [rse_pkg::CMD_W-1:0]         command,
    input  logic signed [rse_pkg::WORD_W-1:0] value,
    input  logic                              last,
    input  rse_pkg::ctrl_cmd_t                cmd,
    output rse_pkg::ctrl_sts_t                sts,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [rse_pkg::WORD_W-1:0] result,
    output logic [rse_pkg::STAT_W-1:0]        status
);

    localparam int W   = rse_pkg::WORD_W;
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int NW  = W + FRAC_BITS;
    localparam logic [63:0] HALF = (FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS - 1)) : 64'd0;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        mag_of = v[W-1] ? (~v + W'(1)) : v;
    endfunction

    // Apply a sign to a magnitude and clamp to the word range
    function automatic logic [W-1:0] sat_mag(input logic [63:0] mag, input logic neg);
        logic [W-1:0] res;
        if (neg)
        begin
            if (mag >= 64'h0000_0000_8000_0000)
                res = {1'b1, {(W-1){1'b0}}};
            else
                res = ~mag[W-1:0] + W'(1);
        end
        else
        begin
            if (mag > 64'h0000_0000_7FFF_FFFF)
                res = {1'b0, {(W-1){1'b1}}};
            else
                res = mag[W-1:0];
        end
        sat_mag = res;
    endfunction

    logic [rse_pkg::CMD_W-1:0]   op_reg;
    logic [W-1:0]                val_reg;
    logic                        last_reg;
    logic [SPW-1:0]              sp_reg;
    logic [SPW-1:0]              sp_next;
    logic [rse_pkg::STAT_W-1:0]  err_reg;
    logic [rse_pkg::STAT_W-1:0]  err_next;
    logic [W-1:0]                top_reg;
    logic [W-1:0]                top_next;
    logic [W-1:0]                rd_data_reg;
    logic [63:0]                 prod_reg;
    logic                        neg_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [W-1:0]                result_reg;
    logic [rse_pkg::STAT_W-1:0]  status_reg;
    logic [rse_pkg::STAT_W-1:0]  emit_status;

    logic [W-1:0]                mem [STACK_DEPTH];

    logic [SPW-1:0]              sp_minus1;
    logic [SPW-1:0]              sp_minus2;
    logic [W-1:0]                mag_below;
    logic [W-1:0]                mag_top;
    logic                        neg_op;
    logic [W:0]                  sum;
    logic [W-1:0]                alu_res;
    logic [63:0]                 rounded;
    logic [W-1:0]                mul_res;
    logic [NW-1:0]               dividend;
    logic [NW-1:0]               quotient;
    logic                        div_done;
    logic [W-1:0]                div_res;
    logic                        out_free;

    always_comb
    begin
        sp_minus1 = sp_reg - SPW'(1);
        sp_minus2 = sp_reg - SPW'(2);
        mag_below = mag_of(rd_data_reg);
        mag_top   = mag_of(top_reg);
        neg_op    = rd_data_reg[W-1] ^ top_reg[W-1];

        if (op_reg == rse_pkg::CMD_SUB)
            sum = {rd_data_reg[W-1], rd_data_reg} - {top_reg[W-1], top_reg};
        else
            sum = {rd_data_reg[W-1], rd_data_reg} + {top_reg[W-1], top_reg};
        if (sum[W] != sum[W-1])
            alu_res = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            alu_res = sum[W-1:0];

        rounded  = (prod_reg + HALF) >> FRAC_BITS;
        mul_res  = sat_mag(rounded, neg_reg);
        dividend = (NW'(mag_below) << FRAC_BITS) + NW'(mag_top >> 1);
        div_res  = sat_mag(64'(quotient), neg_reg);
        out_free = !out_valid_reg || out_ready;

        if (err_reg != rse_pkg::STAT_OK)
            emit_status = err_reg;
        else if (sp_reg == '0)
            emit_status = rse_pkg::STAT_UNDER;
        else
            emit_status = rse_pkg::STAT_OK;
    end

    // Stack pointer, sticky error, top of stack
    always_comb
    begin
        sp_next  = sp_reg;
        err_next = err_reg;
        top_next = top_reg;
        if (cmd.emit)
        begin
            sp_next  = '0;
            err_next = rse_pkg::STAT_OK;
        end
        else
        begin
            if (cmd.push)
                sp_next = sp_reg + SPW'(1);
            else if (cmd.alu_wb || cmd.mul_wb || cmd.div_wb)
                sp_next = sp_minus1;
            if (cmd.set_err)
                err_next = cmd.err_code;
        end
        priority if (cmd.push)
            top_next = val_reg;
        else if (cmd.alu_wb)
            top_next = alu_res;
        else if (cmd.mul_wb)
            top_next = mul_res;
        else if (cmd.div_wb)
            top_next = div_res;
        else
            top_next = top_reg;

        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            err_reg       <= rse_pkg::STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg        <= sp_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (cmd.load_in)
        begin
            op_reg   <= command;
            val_reg  <= value;
            last_reg <= last;
        end
        if (cmd.mul_start)
            prod_reg <= 64'(mag_below) * 64'(mag_top);
        if (cmd.mul_start || cmd.div_start)
            neg_reg <= neg_op;
        if (cmd.emit)
        begin
            status_reg <= emit_status;
            result_reg <= (emit_status == rse_pkg::STAT_OK) ? top_reg : '0;
        end
    end

    // Stack memory: spill the old top on push, fetch the entry below on an operator
    always_ff @(posedge clk)
    begin
        if (cmd.push && (sp_reg != '0))
            mem[sp_minus1[AW-1:0]] <= top_reg;
        if (cmd.rd_en)
            rd_data_reg <= mem[sp_minus2[AW-1:0]];
    end

    rse_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (mag_top),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        sts.op       = op_reg;
        sts.last     = last_reg;
        sts.err_set  = err_reg != rse_pkg::STAT_OK;
        sts.sp_lt2   = sp_reg < SPW'(2);
        sts.sp_full  = sp_reg == SPW'(STACK_DEPTH);
        sts.top_zero = top_reg == '0;
        sts.div_done = div_done;
        sts.out_free = out_free;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign status    = status_reg;

endmodule

/* design/rse_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rse_ctrl: token sequencer of the RPN stack evaluator
// Decodes one token at a time and steers the datapath through its steps.
// ---------------------------------------------------------------------------
module rse_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rse_pkg::ctrl_sts_t sts,
    output rse_pkg::ctrl_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                priority if (sts.err_set || (sts.op > rse_pkg::CMD_DIV))
                begin
                    // sticky error or unknown command: nothing to do
                end
                else if (sts.op == rse_pkg::CMD_PUSH)
                begin
                    if (sts.sp_full)
                    begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = rse_pkg::STAT_OVER;
                    end
                    else
                        cmd.push = 1'b1;
                end
                else if (sts.sp_lt2)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = rse_pkg::STAT_UNDER;
                end
                else if ((sts.op == rse_pkg::CMD_DIV) && sts.top_zero)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = rse_pkg::STAT_DIVZ;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_FINISH;
                if ((sts.op == rse_pkg::CMD_ADD) || (sts.op == rse_pkg::CMD_SUB))
                    cmd.alu_wb = 1'b1;
                else if (sts.op == rse_pkg::CMD_MUL)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_MUL;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_MUL:
            begin
                cmd.mul_wb = 1'b1;
                state_next = S_FINISH;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.div_wb = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!sts.last)
                    state_next = S_IDLE;
                else if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.top_zero)
        else $error("divider started with a zero divisor");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded while the output register is still full");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !sts.sp_full)
        else $error("push on a full stack");

    a_pop_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.alu_wb || cmd.mul_wb || cmd.div_wb) |-> !sts.sp_lt2)
        else $error("operator writeback with fewer than two entries");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DECODE))
        else $error("accepted token not decoded next cycle");

endmodule

/* design/rpn_stack_evaluator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpn_stack_evaluator: Reverse Polish evaluator over a bounded Q16.16 stack
// Steps: push or ignored token decode, finish; add/sub decode, read, finish;
//   multiply adds a multiply step, divide waits on the bit-serial divider.
// Throughput: one token at a time; a new token is taken on return to idle.
//   The result register lets the next token in while a result waits.
// Reset (rst_n, async): stack pointer, error, sequencer and output valid
//   clear at once; the stack memory is not cleared and needs no sweep.
// ---------------------------------------------------------------------------
module rpn_stack_evaluator #(
    parameter int STACK_DEPTH = rse_pkg::DEFAULT_STACK_DEPTH,
    parameter int FRAC_BITS   = rse_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    rse_token_if.sink           token,
    rse_result_if.source        outcome
);

    rse_pkg::ctrl_cmd_t cmd;
    rse_pkg::ctrl_sts_t sts;
    logic               in_ready;

    // Sequencer: one token per transaction, walks decode, fetch, compute, finish
    rse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (token.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: cached top of stack, stack memory, adder, multiplier, divider
    rse_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .command   (token.command),
        .value     (token.value),
        .last      (token.last),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (outcome.valid),
        .out_ready (outcome.ready),
        .result    (outcome.result),
        .status    (outcome.status)
    );

    // Ready only while the sequencer sits idle
    assign token.ready = in_ready;

endmodule

/* tb/rpn_stack_evaluator_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpn_stack_evaluator_checker: result predictor and scoreboard
// Watches both channels, keeps a shadow of the operand stack and the sticky
// error, and compares every result transaction against the oldest forecast.
// ---------------------------------------------------------------------------
module rpn_stack_evaluator_checker #(
    parameter int STACK_DEPTH = rse_pkg::DEFAULT_STACK_DEPTH,
    parameter int FRAC_BITS   = rse_pkg::DEFAULT_FRAC_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    rse_token_if         token,
    rse_result_if        outcome,
    output int           mismatches,
    output int           awaited,
    output int           results_checked,
    output int           status_seen [4]
);
    import rse_pkg::*;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [WORD_W-1:0] result;
        logic [STAT_W-1:0]        status;
    } outcome_t;

    // Shadow machine state
    logic signed [WORD_W-1:0] opnd_stack [STACK_DEPTH];
    int unsigned              depth      = 0;
    logic [STAT_W-1:0]        sticky_err = STAT_OK;

    outcome_t awaited_outcomes [$];
    int       errs    = 0;
    int       checked = 0;
    int       seen_cnt [4] = '{0, 0, 0, 0};

    function automatic logic signed [WORD_W-1:0] clamp_sum(input longint v);
        if (v > 64'sd2147483647)
            return WORD_MAX;
        if (v < -64'sd2147483648)
            return WORD_MIN;
        return v[WORD_W-1:0];
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [WORD_W-1:0] v);
        longint w;
        w = v;
        return (w < 0) ? 64'(-w) : 64'(w);
    endfunction

    function automatic logic signed [WORD_W-1:0] apply_sign(input logic [63:0] mag,
                                                            input bit neg);
        if (neg)
            return (mag >= 64'd2147483648) ? WORD_MIN : -$signed(mag[WORD_W-1:0]);
        return (mag > 64'd2147483647) ? WORD_MAX : $signed(mag[WORD_W-1:0]);
    endfunction

    // Round the full product to nearest, ties away from zero
    function automatic logic signed [WORD_W-1:0] fx_product(
        input logic signed [WORD_W-1:0] a, input logic signed [WORD_W-1:0] b);
        logic [63:0] prod;
        logic [63:0] half;
        prod = magnitude(a) * magnitude(b);
        half = (FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS - 1)) : 64'd0;
        return apply_sign((prod + half) >> FRAC_BITS, (a < 0) != (b < 0));
    endfunction

    // Divisor is known nonzero here
    function automatic logic signed [WORD_W-1:0] fx_quotient(
        input logic signed [WORD_W-1:0] a, input logic signed [WORD_W-1:0] b);
        logic [63:0] mb;
        logic [63:0] num;
        mb  = magnitude(b);
        num = (magnitude(a) << FRAC_BITS) + (mb >> 1);
        return apply_sign(num / mb, (a < 0) != (b < 0));
    endfunction

    task automatic evaluate_token(input logic [CMD_W-1:0] cmd,
                                  input logic signed [WORD_W-1:0] val,
                                  input logic fin);
        logic signed [WORD_W-1:0] top_v;
        logic signed [WORD_W-1:0] below_v;
        logic signed [WORD_W-1:0] r;
        logic [STAT_W-1:0]        st;
        bit                       divz;
        if (sticky_err == STAT_OK)
        begin
            case (cmd)
                CMD_PUSH:
                begin
                    if (depth >= STACK_DEPTH)
                        sticky_err = STAT_OVER;
                    else
                    begin
                        opnd_stack[depth] = val;
                        depth++;
                    end
                end
                CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
                begin
                    if (depth < 2)
                        sticky_err = STAT_UNDER;
                    else
                    begin
                        top_v   = opnd_stack[depth-1];
                        below_v = opnd_stack[depth-2];
                        divz    = 1'b0;
                        r       = '0;
                        case (cmd)
                            CMD_ADD: r = clamp_sum(longint'(below_v) + longint'(top_v));
                            CMD_SUB: r = clamp_sum(longint'(below_v) - longint'(top_v));
                            CMD_MUL: r = fx_product(below_v, top_v);
                            default:
                            begin
                                if (top_v == 0)
                                    divz = 1'b1;
                                else
                                    r = fx_quotient(below_v, top_v);
                            end
                        endcase
                        if (divz)
                            sticky_err = STAT_DIVZ;
                        else
                        begin
                            depth--;
                            opnd_stack[depth-1] = r;
                        end
                    end
                end
                default: ;  // unknown command: no effect
            endcase
        end
        if (fin)
        begin
            st = sticky_err;
            r  = '0;
            if (st == STAT_OK)
            begin
                if (depth == 0)
                    st = STAT_UNDER;
                else
                    r = opnd_stack[depth-1];
            end
            awaited_outcomes.push_back('{result: r, status: st});
            depth      = 0;
            sticky_err = STAT_OK;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t head;
        if (!rst_n)
        begin
            awaited_outcomes.delete();
            depth      = 0;
            sticky_err = STAT_OK;
        end
        else
        begin
            // Retire the result first; a token taken at this edge cannot own it
            if (outcome.valid && outcome.ready)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    $error("unexpected result transaction: result %0d status %0d",
                           outcome.result, outcome.status);
                    errs++;
                end
                else
                begin
                    head = awaited_outcomes.pop_front();
                    if (outcome.result !== head.result)
                    begin
                        $error("field result: expected %0d (0x%08h), actual %0d (0x%08h)",
                               head.result, head.result, outcome.result, outcome.result);
                        errs++;
                    end
                    if (outcome.status !== head.status)
                    begin
                        $error("field status: expected %0d, actual %0d",
                               head.status, outcome.status);
                        errs++;
                    end
                    seen_cnt[head.status]++;
                end
                checked++;
            end
            if (token.valid && token.ready)
                evaluate_token(token.command, token.value, token.last);
        end
        awaited         <= awaited_outcomes.size();
        mismatches      <= errs;
        results_checked <= checked;
        status_seen     <= seen_cnt;
    end

endmodule

/* tb/rpn_stack_evaluator_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpn_stack_evaluator_tb: top of the RPN stack evaluator testbench
// Drives a directed set of expressions covering saturation, rounding ties,
// stack errors and sticky errors, then random well-formed and broken
// expressions under random source gaps and sink stalls. The checker beside
// the block predicts every result and reports mismatches.
// ---------------------------------------------------------------------------
module rpn_stack_evaluator_tb;
    import rse_pkg::*;

    localparam int STACK_DEPTH  = DEFAULT_STACK_DEPTH;
    localparam int FRAC_BITS    = DEFAULT_FRAC_BITS;
    localparam int RANDOM_ITEMS = 1250;
    // Divide latency plus margin for the drain at the end
    localparam int TAIL_CYCLES  = 5 + 32 + FRAC_BITS + 16;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic [CMD_W-1:0]         CMD_NOP5 = 3'd5;
    localparam logic [CMD_W-1:0]         CMD_NOP6 = 3'd6;
    localparam logic [CMD_W-1:0]         CMD_NOP7 = 3'd7;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Set during a long stretch where neither side idles
    bit calm = 1'b0;

    int tokens_sent  = 0;
    int formulas     = 0;
    int mismatches;
    int awaited;
    int results_checked;
    int status_seen [4];

    rse_token_if  tok ();
    rse_result_if res ();

    rpn_stack_evaluator #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .token   (tok),
        .outcome (res)
    );

    rpn_stack_evaluator_checker #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .token           (tok),
        .outcome         (res),
        .mismatches      (mismatches),
        .awaited         (awaited),
        .results_checked (results_checked),
        .status_seen     (status_seen)
    );

    // 12 ns clock
    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Hold reset from start-up, then release it for good
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Sink side: stall about 6 percent of the time, never while calm
    initial
    begin
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res.ready <= calm || ($urandom_range(99) >= 6);
        end
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("Timeout: results still outstanding = %0d", awaited);
        $display("*** FAILED ***");
        $finish;
    end

    // Mix extremes, full-range noise and moderate values that keep the
    // arithmetic out of saturation most of the time
    function automatic logic signed [WORD_W-1:0] pick_value();
        int raw;
        raw = $urandom_range(2097152);
        case ($urandom_range(11))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return ($urandom_range(1) != 0) ? 32'sd1 : -32'sd1;
            4:       return 32'($urandom_range(64)) << FRAC_BITS;
            5, 6:    return $urandom();
            default: return raw - 1048576;
        endcase
    endfunction

    // Present one transaction and hold it until the sink takes it
    task automatic send_token(input logic [CMD_W-1:0] cmd,
                              input logic signed [WORD_W-1:0] val,
                              input logic fin);
        while (!calm && $urandom_range(99) < 6)
        begin
            tok.valid <= 1'b0;
            @(posedge clk);
        end
        tok.valid   <= 1'b1;
        tok.command <= cmd;
        tok.value   <= val;
        tok.last    <= fin;
        do
        begin
            @(posedge clk);
        end
        while (!tok.ready);
        // Count only tokens that do something
        if (cmd <= CMD_DIV || fin)
            tokens_sent++;
    endtask

    // Well-formed expression: n_ops operators over n_ops + 1 operands
    task automatic send_formula(input int n_ops);
        int pushes_left;
        int ops_left;
        int level;
        logic [CMD_W-1:0] op;
        pushes_left = n_ops + 1;
        ops_left    = n_ops;
        level       = 0;
        while (pushes_left + ops_left > 0)
        begin
            if (pushes_left > 0 && (level < 2 || $urandom_range(1) != 0))
            begin
                pushes_left--;
                level++;
                send_token(CMD_PUSH, pick_value(), pushes_left + ops_left == 0);
            end
            else
            begin
                ops_left--;
                level--;
                op = CMD_ADD + CMD_W'($urandom_range(3));
                send_token(op, $urandom(), pushes_left + ops_left == 0);
            end
        end
        formulas++;
    endtask

    // Random commands including unknown ones, with stray end markers
    task automatic send_noise();
        int len;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
            send_token(CMD_W'($urandom_range(7)), pick_value(),
                       (i == len - 1) || ($urandom_range(9) == 0));
        formulas++;
    endtask

    // Fill the stack near or past its limit, then fold a few entries
    task automatic send_deep();
        int fill;
        int n_ops;
        fill  = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 4);
        n_ops = $urandom_range(1, 3);
        for (int i = 0; i < fill; i++)
            send_token(CMD_PUSH, pick_value(), 1'b0);
        for (int i = 0; i < n_ops; i++)
            send_token(CMD_ADD + CMD_W'($urandom_range(3)), $urandom(), i == n_ops - 1);
        formulas++;
    endtask

    // Stimulus
    initial
    begin
        int roll;
        int first_random;
        tok.valid   <= 1'b0;
        tok.command <= CMD_PUSH;
        tok.value   <= '0;
        tok.last    <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        @(posedge clk);

        // Add saturating high
        send_token(CMD_PUSH, WORD_MAX, 1'b0);
        send_token(CMD_PUSH, 32'sd1, 1'b0);
        send_token(CMD_ADD, WORD_MIN, 1'b1);
        // Subtract saturating low
        send_token(CMD_PUSH, WORD_MIN, 1'b0);
        send_token(CMD_PUSH, 32'sd1, 1'b0);
        send_token(CMD_SUB, WORD_MAX, 1'b1);
        // Multiply on an exact rounding tie, negative side
        send_token(CMD_PUSH, 32'sd1, 1'b0);
        send_token(CMD_PUSH, -32'sd32768, 1'b0);
        send_token(CMD_MUL, '0, 1'b1);
        // Multiply of the two most negative operands saturates high
        send_token(CMD_PUSH, WORD_MIN, 1'b0);
        send_token(CMD_PUSH, WORD_MIN, 1'b0);
        send_token(CMD_MUL, WORD_MAX, 1'b1);
        // Divide on a rounding tie, negative quotient
        send_token(CMD_PUSH, -32'sd1, 1'b0);
        send_token(CMD_PUSH, 32'sh0002_0000, 1'b0);
        send_token(CMD_DIV, '0, 1'b1);
        // Divide by zero
        send_token(CMD_PUSH, 32'sd5, 1'b0);
        send_token(CMD_PUSH, '0, 1'b0);
        send_token(CMD_DIV, '0, 1'b1);
        // Emit on an empty stack through an unknown command
        send_token(CMD_NOP7, WORD_MAX, 1'b1);
        // Single operand expression
        send_token(CMD_PUSH, WORD_MIN, 1'b1);
        // Underflow stays sticky past later valid work
        send_token(CMD_PUSH, 32'sd7, 1'b0);
        send_token(CMD_NOP6, '0, 1'b0);
        send_token(CMD_MUL, '0, 1'b0);
        send_token(CMD_PUSH, 32'sd2, 1'b0);
        send_token(CMD_ADD, '0, 1'b1);
        // Unknown command between operands is a no-op
        send_token(CMD_PUSH, 32'sh0003_0000, 1'b0);
        send_token(CMD_NOP5, '1, 1'b0);
        send_token(CMD_PUSH, 32'sh0001_8000, 1'b0);
        send_token(CMD_DIV, '0, 1'b1);

        first_random = tokens_sent;
        while (tokens_sent - first_random < RANDOM_ITEMS)
        begin
            // Hold both sides busy for a long stretch in the middle
            calm <= (tokens_sent - first_random >= 450) &&
                    (tokens_sent - first_random < 750);
            roll = $urandom_range(99);
            if (roll < 2)
                send_deep();
            else if (roll < 18)
                send_noise();
            else
                send_formula($urandom_range(0, 7));
        end
        tok.valid <= 1'b0;
        calm      <= 1'b0;

        // Drain every forecast result, then watch for strays
        do
        begin
            @(posedge clk);
        end
        while (awaited != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d tokens in %0d expressions; checked %0d results.",
                 tokens_sent, formulas, results_checked);
        $display("Status mix: ok %0d, underflow %0d, overflow %0d, divide by zero %0d.",
                 status_seen[STAT_OK], status_seen[STAT_UNDER],
                 status_seen[STAT_OVER], status_seen[STAT_DIVZ]);
        if (mismatches == 0 && awaited == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
